@@ hw/rtl/sledm_pkg.sv @@
// Shared types, codes and constants of the sized little-endian data memory.
// No dependencies; every other RTL file but sledm_bank imports this package.
`default_nettype none

package sledm_pkg;

  // Geometry defaults
  localparam int unsigned MEM_BYTES_DEF = 4096;
  localparam int unsigned LANES         = 4;
  localparam logic [31:0] BASE_RESET    = 32'h1001_0000;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_BASE   = 1'b0;

  // Operation codes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_APPEND = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Access size codes; the spare code behaves as a word
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISALIGN = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  access_size;
    logic [31:0] address;
    logic [31:0] write_value;
  } sledm_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } sledm_out_t;

  // Access info carried alongside the memory read
  typedef struct packed {
    logic       vld;
    logic       rd;
    logic [1:0] lo;
    logic [1:0] size;
    logic [1:0] status;
  } sledm_meta_t;

  // Byte count of an access size code
  function automatic logic [2:0] size_bytes(input logic [1:0] code);
    logic [2:0] nb;
    case (code)
      SZ_BYTE: nb = 3'd1;
      SZ_HALF: nb = 3'd2;
      SZ_WORD: nb = 3'd4;
      default: nb = 3'd4;
    endcase
    return nb;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sledm_bank.sv @@
// One byte lane of the data store: single-port synchronous RAM, registered read.
// Uses no package items.
`default_nettype none

module sledm_bank #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned ROW_W = 10
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [ROW_W-1:0] row,
  input  wire logic [7:0]       wdata,
  output logic      [7:0]       rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  // Write or read one row per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[row] <= wdata;
      end else begin
        rdata_r <= mem_r[row];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/sledm_cfg.sv @@
// APB register block holding the data base address.
// Depends on sledm_pkg for port widths, register index and reset value.
`default_nettype none

module sledm_cfg
  import sledm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [31:0]           base_addr
);

  logic [31:0] base_r;
  logic        wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == REG_BASE);

  // Capture the base on the access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (wr_hit) begin
      base_r <= pwdata;
    end
  end

  assign prdata    = (paddr[2] == REG_BASE) ? base_r : '0;
  assign base_addr = base_r;

endmodule

`default_nettype wire

@@ hw/rtl/sledm_access.sv @@
// Address stage: offset, range and alignment checks, append pointer, lane requests.
// Depends on sledm_pkg for item types and codes.
`default_nettype none

module sledm_access
  import sledm_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF,
  parameter int unsigned ROW_W     = 10,
  parameter int unsigned AP_W      = 13
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              fire,
  input  wire sledm_in_t                         item,
  input  wire logic      [31:0]                  base,
  input  wire logic                              clr_active,
  input  wire logic      [ROW_W-1:0]             clr_row,
  output logic           [LANES-1:0]             bank_en,
  output logic           [LANES-1:0]             bank_we,
  output logic           [LANES-1:0][ROW_W-1:0]  bank_row,
  output logic           [LANES-1:0][7:0]        bank_wdata,
  output sledm_meta_t                            meta
);

  localparam logic [31:0] MEM_LIM = 32'(MEM_BYTES);

  logic [AP_W-1:0] ap_r;
  logic [AP_W-1:0] ap_nxt;
  logic [2:0]      nb;
  logic [1:0]      amask;
  logic [31:0]     off;
  logic [31:0]     lim;
  logic            ldst_ok;
  logic            misal;
  logic [AP_W:0]   p_ext;
  logic            app_ok;
  logic [31:0]     eo;
  logic [ROW_W-1:0] row;
  logic [1:0]      lo;
  logic            do_rd;
  logic            do_wr;
  logic            do_app;
  logic [1:0]      status;

  // Size, offset and checks
  assign nb      = size_bytes(item.access_size);
  assign amask   = 2'(nb - 3'd1);
  assign off     = item.address - base;
  assign lim     = MEM_LIM - {29'd0, nb};
  assign ldst_ok = (off <= lim);
  assign misal   = |(item.address[1:0] & amask);

  // Round the append pointer up to the access alignment
  assign p_ext  = ({1'b0, ap_r} + (AP_W+1)'(amask)) & ~((AP_W+1)'(amask));
  assign app_ok = (32'(p_ext) <= lim);

  // Decode the operation
  always_comb begin
    do_rd  = 1'b0;
    do_wr  = 1'b0;
    do_app = 1'b0;
    status = ST_OK;
    case (item.operation)
      OP_LOAD: begin
        do_rd  = ldst_ok;
        status = ldst_ok ? ST_OK : ST_RANGE;
      end
      OP_STORE: begin
        if (misal) begin
          status = ST_MISALIGN;
        end else if (!ldst_ok) begin
          status = ST_RANGE;
        end else begin
          do_wr = 1'b1;
        end
      end
      OP_APPEND: begin
        do_wr  = app_ok;
        do_app = app_ok;
        status = app_ok ? ST_OK : ST_RANGE;
      end
      OP_NONE: begin
        status = ST_OK;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign eo  = (item.operation == OP_APPEND) ? 32'(p_ext) : off;
  assign row = eo[ROW_W+1:2];
  assign lo  = eo[1:0];

  // Route each byte of the access to its lane
  always_comb begin
    logic [1:0] j;
    for (int b = 0; b < LANES; b++) begin
      j = 2'(b) - lo;
      if (clr_active) begin
        bank_en[b]    = 1'b1;
        bank_we[b]    = 1'b1;
        bank_row[b]   = clr_row;
        bank_wdata[b] = 8'h00;
      end else begin
        bank_en[b]    = fire && ({1'b0, j} < nb) && (do_rd || do_wr);
        bank_we[b]    = do_wr;
        bank_row[b]   = row + ((2'(b) < lo) ? ROW_W'(1) : ROW_W'(0));
        bank_wdata[b] = item.write_value[8*j +: 8];
      end
    end
  end

  // Advance the append pointer past a successful append
  assign ap_nxt = (fire && do_app) ? AP_W'(p_ext + (AP_W+1)'(nb)) : ap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_r <= '0;
    end else begin
      ap_r <= ap_nxt;
    end
  end

  assign meta.vld    = fire;
  assign meta.rd     = do_rd;
  assign meta.lo     = lo;
  assign meta.size   = item.access_size;
  assign meta.status = status;

  a_ap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ap_r <= AP_W'(MEM_BYTES))
    else $error("append pointer past end of store");

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_rd && do_wr))
    else $error("access both reads and writes");

endmodule

`default_nettype wire

@@ hw/rtl/sledm_result.sv @@
// Result stage: lane realignment, sign extension and a four-entry output buffer.
// Depends on sledm_pkg for the meta and result types and size codes.
`default_nettype none

module sledm_result
  import sledm_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sledm_meta_t                 meta,
  input  wire logic        [LANES-1:0][7:0] bank_q,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output sledm_out_t                       out_data,
  output logic                             space_ok
);

  sledm_meta_t m_r;
  sledm_out_t  buf_r [4];
  logic [1:0]  wp_r;
  logic [1:0]  rp_r;
  logic [2:0]  cnt_r;
  logic [2:0]  cnt_nxt;
  logic [31:0] raw;
  logic [31:0] ext;
  sledm_out_t  res;
  logic        push;
  logic        pop;

  // Hold the access info for the cycle the lanes are read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= '0;
    end else begin
      m_r <= meta;
    end
  end

  // Rotate lanes back into byte order
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      raw[8*j +: 8] = bank_q[2'(j) + m_r.lo];
    end
  end

  // Sign-extend to 32 bits
  always_comb begin
    case (m_r.size)
      SZ_BYTE: ext = {{24{raw[7]}}, raw[7:0]};
      SZ_HALF: ext = {{16{raw[15]}}, raw[15:0]};
      default: ext = raw;
    endcase
  end

  assign res.read_value = m_r.rd ? $signed(ext) : '0;
  assign res.status     = m_r.status;

  // Output buffer
  assign push     = m_r.vld;
  assign out_valid = (cnt_r != 3'd0);
  assign pop      = out_valid && out_ready;
  assign out_data = buf_r[rp_r];
  assign cnt_nxt  = cnt_r + {2'd0, push} - {2'd0, pop};
  assign space_ok = ((cnt_r + {2'd0, m_r.vld}) <= 3'd3);

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + {1'b0, push};
      rp_r  <= rp_r + {1'b0, pop};
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("output buffer overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    m_r.vld |-> cnt_r < 3'd4)
    else $error("result arrives at a full buffer");

endmodule

`default_nettype wire

@@ hw/rtl/sized_little_endian_data_memory.sv @@
// Top level of the sized little-endian data memory: input stage, clear sequencer,
// four byte-lane banks. Depends on sledm_pkg, sledm_cfg, sledm_bank,
// sledm_access and sledm_result.
//
//   channel | ports                        | beat
//   --------+------------------------------+----------------------------------
//   input   | in_valid in_ready in_data    | one load, store or append
//   result  | out_valid out_ready out_data | read_value and status
//   config  | psel penable pwrite paddr .. | base address write, APB timing
//
// One item per cycle while the output buffer has room; a result passes the input
// register, the bank access and the output buffer write before it is offered.
// After reset a clearing pass zeroes one row of all four lanes per cycle,
// through every row (1024 by default); in_ready stays low until it ends.
// A stalled result side fills a four-entry output buffer; the input stage
// holds its item once that buffer cannot take another in-flight result.
`default_nettype none

module sized_little_endian_data_memory
  import sledm_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire sledm_in_t             in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output sledm_out_t                 out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned ROWS  = (MEM_BYTES + LANES - 1) / LANES;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned AP_W  = $clog2(MEM_BYTES + 1);

  sledm_in_t   s1_r;
  logic        s1_vld_r;
  logic        s1_vld_nxt;
  logic        fire;
  logic        space_ok;
  logic        clr_done_r;
  logic [ROW_W-1:0] clr_row_r;
  logic [31:0] base;
  sledm_meta_t meta;
  logic [LANES-1:0]            bank_en;
  logic [LANES-1:0]            bank_we;
  logic [LANES-1:0][ROW_W-1:0] bank_row;
  logic [LANES-1:0][7:0]       bank_wdata;
  logic [LANES-1:0][7:0]       bank_q;

  // Configuration registers
  sledm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .base_addr (base)
  );

  // Clear all rows after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_done_r <= 1'b0;
      clr_row_r  <= '0;
    end else if (!clr_done_r) begin
      clr_row_r <= clr_row_r + ROW_W'(1);
      if (clr_row_r == ROW_W'(ROWS - 1)) begin
        clr_done_r <= 1'b1;
      end
    end
  end

  // Input stage: issue when the result side has room
  assign fire       = s1_vld_r && space_ok && clr_done_r;
  assign in_ready   = clr_done_r && (!s1_vld_r || fire);
  assign s1_vld_nxt = (in_valid && in_ready) || (s1_vld_r && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
  end

  sledm_access #(
    .MEM_BYTES (MEM_BYTES),
    .ROW_W     (ROW_W),
    .AP_W      (AP_W)
  ) u_access (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (s1_r),
    .base       (base),
    .clr_active (!clr_done_r),
    .clr_row    (clr_row_r),
    .bank_en    (bank_en),
    .bank_we    (bank_we),
    .bank_row   (bank_row),
    .bank_wdata (bank_wdata),
    .meta       (meta)
  );

  // Byte lanes
  for (genvar b = 0; b < LANES; b++) begin : g_lane
    sledm_bank #(
      .DEPTH (ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk   (clk),
      .en    (bank_en[b]),
      .we    (bank_we[b]),
      .row   (bank_row[b]),
      .wdata (bank_wdata[b]),
      .rdata (bank_q[b])
    );
  end

  sledm_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .meta      (meta),
    .bank_q    (bank_q),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .space_ok  (space_ok)
  );

  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done_r |-> !in_ready)
    else $error("input taken during clearing pass");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !fire |=> s1_vld_r && $stable(s1_r))
    else $error("stalled item lost");

endmodule

`default_nettype wire
